>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BOIDS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BOIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/boids_pkg.sv
// ---------------------------------------------------------------------------
// Boids steering package
// Types, codes, saturation and magnitude helpers shared by the steering block.
// ---------------------------------------------------------------------------
package boids_pkg;

   typedef logic signed [31:0] q_type;     // Q16.16 value
   typedef logic signed [47:0] sum_type;   // saturating accumulator
   typedef logic signed [33:0] vec_type;   // difference vector component
   typedef logic signed [32:0] norm_type;  // normalized component

   localparam logic REQ_LOAD     = 1'b0;
   localparam logic REQ_NEIGHBOR = 1'b1;

   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSE_RANGE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COHESION_WEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVOIDANCE_WEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNMENT_WEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_STEP        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_FACTOR     = 3'd5;

   localparam logic [16:0] BLEND_ONE  = 17'd65536;
   localparam int unsigned BLEND_BITS = 16;

   function automatic q_type sat32(input logic signed [63:0] x);
      if (x > 64'sh0000_0000_7fff_ffff) begin
         return 32'h7fff_ffff;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic sum_type sat48(input logic signed [49:0] x);
      if (x > 50'sh0_7fff_ffff_ffff) begin
         return 48'h7fff_ffff_ffff;
      end else if (x < -50'sh0_8000_0000_0000) begin
         return 48'h8000_0000_0000;
      end
      return x[47:0];
   endfunction

   function automatic logic [33:0] mag34(input vec_type v);
      return v[33] ? 34'(-v) : 34'(v);
   endfunction

   function automatic logic [47:0] mag48(input sum_type v);
      return v[47] ? 48'(-v) : 48'(v);
   endfunction

endpackage

>>> hdl/boids_req_if.sv
// ---------------------------------------------------------------------------
// Boids request channel
// Valid/ready channel that carries load and neighbor requests.
// ---------------------------------------------------------------------------
interface boids_req_if
   import boids_pkg::*;
;
   logic  valid;
   logic  ready;
   logic  req_type;
   q_type pos_x;
   q_type pos_y;
   q_type pos_z;
   q_type dir_x;
   q_type dir_y;
   q_type dir_z;
   logic  is_self;
   logic  last_neighbor;

   modport source (output valid, req_type, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                   is_self, last_neighbor, input ready);
   modport sink   (input valid, req_type, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                   is_self, last_neighbor, output ready);
endinterface

>>> hdl/boids_rsp_if.sv
// ---------------------------------------------------------------------------
// Boids response channel
// Valid/ready channel that carries the updated agent state.
// ---------------------------------------------------------------------------
interface boids_rsp_if
   import boids_pkg::*;
;
   logic  valid;
   logic  ready;
   q_type new_pos_x;
   q_type new_pos_y;
   q_type new_pos_z;
   q_type new_dir_x;
   q_type new_dir_y;
   q_type new_dir_z;

   modport source (output valid, new_pos_x, new_pos_y, new_pos_z,
                   new_dir_x, new_dir_y, new_dir_z, input ready);
   modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z,
                   new_dir_x, new_dir_y, new_dir_z, output ready);
endinterface

>>> hdl/boids_agent_steering_update.sv
// ---------------------------------------------------------------------------
// Boids agent steering update
// One agent's flocking step: gathers neighbors, then steers, blends and moves.
// ---------------------------------------------------------------------------
// A neighbor request runs the bit-serial square root and, inside the avoidance
// radius, the restoring divider (max(34 + FRAC_BITS, 48) dividend bits, 50 at
// Q16.16). The update on the last neighbor adds the mean divides when a neighbor
// was near, up to two normalizations and the weighting, blending and moving.
// One request is in flight at a time. Reset is synchronous and restores the
// register defaults, zeroes the agent state and sums and empties the output.
module boids_agent_steering_update
   import boids_pkg::*;
#(
   parameter int MAX_NEIGHBORS = 256,
   parameter int FRAC_BITS     = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   boids_req_if.sink            req_chan,
   boids_rsp_if.source          rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   // Widths. The divider serves both the normalizing divides (magnitude
   // shifted up by the fraction bits) and the mean divides (48 bit sums).
   localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
   localparam int LEN_W  = 36;
   localparam int DVD_W  = (34 + FRAC_BITS > 48) ? 34 + FRAC_BITS : 48;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQ   = 4'd1;  // sum of squares on the multiplier
   localparam logic [3:0] S_SQRT = 4'd2;  // one result bit per cycle
   localparam logic [3:0] S_NDIV = 4'd3;  // three normalizing divides
   localparam logic [3:0] S_NEND = 4'd4;  // consume the normalized vector
   localparam logic [3:0] S_FIN  = 4'd5;  // start of the update
   localparam logic [3:0] S_MDIV = 4'd6;  // six mean divides
   localparam logic [3:0] S_WMUL = 4'd7;  // weighting, blending and moving
   localparam logic [3:0] S_OUT  = 4'd8;  // hand the new state to the output

   // What the current normalization is for.
   localparam logic [1:0] PASS_NEIGH = 2'd0;
   localparam logic [1:0] PASS_COH   = 2'd1;
   localparam logic [1:0] PASS_HEAD  = 2'd2;

   // Control and configuration.
   logic [3:0]       state_ff, state_in;
   logic [2:0]       idx_ff, idx_in;
   logic [5:0]       step_ff, step_in;
   logic [1:0]       pass_ff, pass_in;
   logic             last_ff, last_in;
   logic [30:0]      sense_ff, sense_in;
   q_type            cw_ff, cw_in;
   q_type            aw_ff, aw_in;
   q_type            alw_ff, alw_in;
   logic [30:0]      move_ff, move_in;
   logic [16:0]      blend_ff, blend_in;

   // Agent state and sums.
   q_type            own_pos_ff [3], own_pos_in [3];
   q_type            own_dir_ff [3], own_dir_in [3];
   sum_type          coh_sum_ff [3], coh_sum_in [3];
   sum_type          head_sum_ff [3], head_sum_in [3];
   sum_type          rep_sum_ff [3], rep_sum_in [3];
   logic [CNT_W-1:0] near_cnt_ff, near_cnt_in;

   // Divider and output control.
   logic             drun_ff, drun_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers (no reset needed).
   q_type            nb_pos_ff [3], nb_pos_in [3];
   q_type            nb_dir_ff [3], nb_dir_in [3];
   vec_type          vec_ff [3], vec_in [3];
   norm_type         norm_ff [3], norm_in [3];
   norm_type         coh_ff [3], coh_in [3];
   q_type            al_ff [3], al_in [3];
   logic [LEN_W-1:0] len_ff, len_in;
   logic [63:0]      sq_sum_ff, sq_sum_in;
   logic [63:0]      sq_n_ff, sq_n_in;
   logic [63:0]      sq_r_ff, sq_r_in;
   logic [63:0]      sq_b_ff, sq_b_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   q_type            steer_ff, steer_in;
   q_type            nd_ff, nd_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [LEN_W:0]   rem_ff, rem_in;
   logic [LEN_W-1:0] dsr_ff, dsr_in;
   logic             dneg_ff, dneg_in;
   q_type            rsp_pos_ff [3], rsp_pos_in [3];
   q_type            rsp_dir_ff [3], rsp_dir_in [3];

   // Combinational helpers.
   q_type            req_pos [3];
   q_type            req_dir [3];
   logic [33:0]      sq_mag [3];
   logic [33:0]      sq_max;
   logic [1:0]       sq_shift;
   logic [1:0]       sq_sel;
   logic [30:0]      sq_op;
   logic [63:0]      sq_t;
   logic             sq_ge;
   logic [63:0]      sq_r_nx;
   logic [63:0]      sq_n_nx;
   logic [LEN_W-1:0] len_fin;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic [LEN_W:0]   rem_sh;
   logic             div_ge;
   logic [LEN_W:0]   rem_nx;
   logic [DVD_W-1:0] dvd_nx;
   logic [DVD_W-1:0] div_dvd_src;
   logic [LEN_W-1:0] div_dsr_src;
   logic             div_neg_src;
   logic signed [DVD_W:0] div_qs;
   q_type            qmean;
   norm_type         nq;
   sum_type          msum;
   logic [1:0]       i2;
   logic [1:0]       m3;
   logic [16:0]      blend_c;
   logic [16:0]      one_minus;
   q_type            np_w;

   assign req_pos[0] = req_chan.pos_x;
   assign req_pos[1] = req_chan.pos_y;
   assign req_pos[2] = req_chan.pos_z;
   assign req_dir[0] = req_chan.dir_x;
   assign req_dir[1] = req_chan.dir_y;
   assign req_dir[2] = req_chan.dir_z;

   // The block takes a request only when the sequencer is idle.
   assign req_chan.ready = (state_ff == S_IDLE);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.new_pos_x = rsp_pos_ff[0];
   assign rsp_chan.new_pos_y = rsp_pos_ff[1];
   assign rsp_chan.new_pos_z = rsp_pos_ff[2];
   assign rsp_chan.new_dir_x = rsp_dir_ff[0];
   assign rsp_chan.new_dir_y = rsp_dir_ff[1];
   assign rsp_chan.new_dir_z = rsp_dir_ff[2];

   // The one shared multiplier; its product is registered every cycle.
   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[63:0];

   assign i2 = idx_ff[1:0];
   assign m3 = 2'(idx_ff - 3'd3);

   // Blend factors above one act as one.
   assign blend_c   = (blend_ff > BLEND_ONE) ? BLEND_ONE : blend_ff;
   assign one_minus = BLEND_ONE - blend_c;

   // Length prescale: the smallest shift that brings every magnitude of the
   // working vector below 2^31, so that each square fits the multiplier.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_mag[i] = mag34(vec_ff[i]);
      end
      sq_max = sq_mag[0];
      if (sq_mag[1] > sq_max) begin
         sq_max = sq_mag[1];
      end
      if (sq_mag[2] > sq_max) begin
         sq_max = sq_mag[2];
      end
      sq_shift = '0;
      for (int k = 0; k < 3; k++) begin
         if ((sq_max >> sq_shift) >= 34'h0_8000_0000) begin
            sq_shift = sq_shift + 2'd1;
         end
      end
      sq_sel = (step_ff < 6'd3) ? step_ff[1:0] : 2'd0;
      sq_op  = 31'(sq_mag[sq_sel] >> sq_shift);
   end

   // One step of the digit-by-digit square root.
   always_comb begin
      sq_t    = sq_r_ff + sq_b_ff;
      sq_ge   = (sq_n_ff >= sq_t);
      sq_r_nx = sq_ge ? ((sq_r_ff >> 1) + sq_b_ff) : (sq_r_ff >> 1);
      sq_n_nx = sq_ge ? (sq_n_ff - sq_t) : sq_n_ff;
      len_fin = LEN_W'(sq_r_nx[31:0]) << sq_shift;
   end

   // One step of the restoring divider; the quotient shifts into the
   // dividend register as the dividend bits shift out.
   always_comb begin
      rem_sh = {rem_ff[LEN_W-1:0], dvd_ff[DVD_W-1]};
      div_ge = (rem_sh >= {1'b0, dsr_ff});
      rem_nx = div_ge ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
      dvd_nx = {dvd_ff[DVD_W-2:0], div_ge};
      div_qs = dneg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
      qmean  = sat32(64'(div_qs));
      nq     = $signed({1'b0, dvd_ff[31:0]});
      msum   = (idx_ff < 3'd3) ? coh_sum_ff[i2] : head_sum_ff[m3];
      np_w   = sat32(64'(own_pos_ff[i2]) + (prod_ff >>> FRAC_BITS));
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      last_in      = last_ff;
      sense_in     = sense_ff;
      cw_in        = cw_ff;
      aw_in        = aw_ff;
      alw_in       = alw_ff;
      move_in      = move_ff;
      blend_in     = blend_ff;
      own_pos_in   = own_pos_ff;
      own_dir_in   = own_dir_ff;
      coh_sum_in   = coh_sum_ff;
      head_sum_in  = head_sum_ff;
      rep_sum_in   = rep_sum_ff;
      near_cnt_in  = near_cnt_ff;
      drun_in      = drun_ff;
      dcnt_in      = dcnt_ff;
      nb_pos_in    = nb_pos_ff;
      nb_dir_in    = nb_dir_ff;
      vec_in       = vec_ff;
      norm_in      = norm_ff;
      coh_in       = coh_ff;
      al_in        = al_ff;
      len_in       = len_ff;
      sq_sum_in    = sq_sum_ff;
      sq_n_in      = sq_n_ff;
      sq_r_in      = sq_r_ff;
      sq_b_in      = sq_b_ff;
      acc_in       = acc_ff;
      steer_in     = steer_ff;
      nd_in        = nd_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      dneg_in      = dneg_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_dir_in   = rsp_dir_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_dvd_src  = '0;
      div_dsr_src  = '0;
      div_neg_src  = 1'b0;

      // The output register drains independently of the sequencer.
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
      if (csr_we) begin
         unique case (csr_index)
            CSR_SENSE_RANGE:      sense_in = csr_wdata[30:0];
            CSR_COHESION_WEIGHT:  cw_in    = csr_wdata;
            CSR_AVOIDANCE_WEIGHT: aw_in    = csr_wdata;
            CSR_ALIGNMENT_WEIGHT: alw_in   = csr_wdata;
            CSR_MOVE_STEP:        move_in  = csr_wdata[30:0];
            CSR_BLEND_FACTOR:     blend_in = csr_wdata[16:0];
            default: ;
         endcase
      end

      // Divider operands for the state that uses it.
      if (state_ff == S_NDIV) begin
         div_dvd_src = DVD_W'(mag34(vec_ff[i2])) << FRAC_BITS;
         div_dsr_src = len_ff;
         div_neg_src = vec_ff[i2][33];
      end else begin
         div_dvd_src = DVD_W'(mag48(msum));
         div_dsr_src = LEN_W'(near_cnt_ff);
         div_neg_src = msum[47];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.req_type == REQ_LOAD) begin
                  // A load replaces the agent state and starts fresh sums.
                  for (int i = 0; i < 3; i++) begin
                     own_pos_in[i]  = req_pos[i];
                     own_dir_in[i]  = req_dir[i];
                     coh_sum_in[i]  = '0;
                     head_sum_in[i] = '0;
                     rep_sum_in[i]  = '0;
                  end
                  near_cnt_in = '0;
               end else if (req_chan.is_self) begin
                  // The agent's own entry adds nothing but may still end the list.
                  if (req_chan.last_neighbor) begin
                     state_in = S_FIN;
                  end
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     vec_in[i]    = vec_type'(own_pos_ff[i]) - vec_type'(req_pos[i]);
                     nb_pos_in[i] = req_pos[i];
                     nb_dir_in[i] = req_dir[i];
                  end
                  last_in  = req_chan.last_neighbor;
                  pass_in  = PASS_NEIGH;
                  step_in  = '0;
                  state_in = S_SQ;
               end
            end
         end

         S_SQ: begin
            mul_a = $signed({2'b00, sq_op});
            mul_b = $signed({2'b00, sq_op});
            if (step_ff == 6'd0) begin
               sq_sum_in = '0;
            end else begin
               sq_sum_in = sq_sum_ff + $unsigned(prod_ff);
            end
            if (step_ff == 6'd3) begin
               sq_n_in  = sq_sum_ff + $unsigned(prod_ff);
               sq_r_in  = '0;
               sq_b_in  = 64'h4000_0000_0000_0000;
               step_in  = '0;
               state_in = S_SQRT;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end

         S_SQRT: begin
            sq_r_in = sq_r_nx;
            sq_n_in = sq_n_nx;
            sq_b_in = sq_b_ff >> 2;
            if (step_ff == 6'd31) begin
               len_in  = len_fin;
               step_in = '0;
               idx_in  = '0;
               // Neighbors only divide when they fall inside the avoidance
               // radius; a zero length always normalizes to zero.
               if (len_fin != '0 &&
                   (pass_ff != PASS_NEIGH || len_fin < LEN_W'(sense_ff))) begin
                  state_in = S_NDIV;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     norm_in[i] = '0;
                  end
                  state_in = S_NEND;
               end
            end else begin
               step_in = step_ff + 6'd1;
            end
         end

         S_NDIV: begin
            if (!drun_ff) begin
               drun_in = 1'b1;
               dcnt_in = DCNT_W'(DVD_W);
               dvd_in  = div_dvd_src;
               rem_in  = '0;
               dsr_in  = div_dsr_src;
               dneg_in = div_neg_src;
            end else if (dcnt_ff != '0) begin
               dvd_in  = dvd_nx;
               rem_in  = rem_nx;
               dcnt_in = dcnt_ff - DCNT_W'(1);
            end else begin
               drun_in     = 1'b0;
               norm_in[i2] = dneg_ff ? -nq : nq;
               if (idx_ff == 3'd2) begin
                  state_in = S_NEND;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end

         S_NEND: begin
            case (pass_ff)
               PASS_NEIGH: begin
                  // Outside the avoidance radius the normalized vector is zero.
                  for (int i = 0; i < 3; i++) begin
                     rep_sum_in[i] = sat48(50'(rep_sum_ff[i]) + 50'(norm_ff[i]));
                  end
                  if (len_ff < LEN_W'({sense_ff, 1'b0}) &&
                      near_cnt_ff < CNT_W'(MAX_NEIGHBORS)) begin
                     for (int i = 0; i < 3; i++) begin
                        coh_sum_in[i]  = sat48(50'(coh_sum_ff[i]) + 50'(nb_pos_ff[i]));
                        head_sum_in[i] = sat48(50'(head_sum_ff[i]) + 50'(nb_dir_ff[i]));
                     end
                     near_cnt_in = near_cnt_ff + CNT_W'(1);
                  end
                  state_in = last_ff ? S_FIN : S_IDLE;
               end
               PASS_COH: begin
                  coh_in = norm_ff;
                  for (int i = 0; i < 3; i++) begin
                     vec_in[i] = vec_type'(own_dir_ff[i]);
                  end
                  pass_in  = PASS_HEAD;
                  step_in  = '0;
                  state_in = S_SQ;
               end
               PASS_HEAD: begin
                  idx_in   = '0;
                  step_in  = '0;
                  state_in = S_WMUL;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_FIN: begin
            if (near_cnt_ff == '0) begin
               // No near neighbors: cohesion and alignment drop out.
               for (int i = 0; i < 3; i++) begin
                  coh_in[i] = '0;
                  al_in[i]  = '0;
                  vec_in[i] = vec_type'(own_dir_ff[i]);
               end
               pass_in  = PASS_HEAD;
               step_in  = '0;
               state_in = S_SQ;
            end else begin
               idx_in   = '0;
               state_in = S_MDIV;
            end
         end

         S_MDIV: begin
            if (!drun_ff) begin
               drun_in = 1'b1;
               dcnt_in = DCNT_W'(DVD_W);
               dvd_in  = div_dvd_src;
               rem_in  = '0;
               dsr_in  = div_dsr_src;
               dneg_in = div_neg_src;
            end else if (dcnt_ff != '0) begin
               dvd_in  = dvd_nx;
               rem_in  = rem_nx;
               dcnt_in = dcnt_ff - DCNT_W'(1);
            end else begin
               drun_in = 1'b0;
               if (idx_ff < 3'd3) begin
                  // Offset from the agent to the mean position.
                  vec_in[i2] = vec_type'(qmean) - vec_type'(own_pos_ff[i2]);
               end else begin
                  al_in[m3] = sat32(64'(qmean) - 64'(own_dir_ff[m3]));
               end
               if (idx_ff == 3'd5) begin
                  pass_in  = PASS_COH;
                  step_in  = '0;
                  state_in = S_SQ;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end

         S_WMUL: begin
            // Each product issued in one step is read back in the next.
            step_in = step_ff + 6'd1;
            case (step_ff)
               6'd0: begin
                  mul_a = 33'(cw_ff);
                  mul_b = coh_ff[i2];
               end
               6'd1: begin
                  mul_a  = 33'(aw_ff);
                  mul_b  = 33'(sat32(64'(rep_sum_ff[i2])));
                  acc_in = prod_ff;
               end
               6'd2: begin
                  mul_a  = 33'(alw_ff);
                  mul_b  = 33'(al_ff[i2]);
                  acc_in = acc_ff + prod_ff;
               end
               6'd3: begin
                  steer_in = sat32((acc_ff + prod_ff) >>> FRAC_BITS);
               end
               6'd4: begin
                  mul_a = $signed({16'd0, one_minus});
                  mul_b = 33'(steer_ff);
               end
               6'd5: begin
                  mul_a  = $signed({16'd0, blend_c});
                  mul_b  = norm_ff[i2];
                  acc_in = prod_ff;
               end
               6'd6: begin
                  nd_in = sat32((acc_ff + prod_ff) >>> BLEND_BITS);
               end
               6'd7: begin
                  mul_a = 33'(nd_ff);
                  mul_b = $signed({2'b00, move_ff});
               end
               6'd8: begin
                  own_pos_in[i2] = np_w;
                  own_dir_in[i2] = nd_ff;
                  step_in        = '0;
                  if (idx_ff == 3'd2) begin
                     for (int i = 0; i < 3; i++) begin
                        coh_sum_in[i]  = '0;
                        head_sum_in[i] = '0;
                        rep_sum_in[i]  = '0;
                     end
                     near_cnt_in = '0;
                     state_in    = S_OUT;
                  end else begin
                     idx_in = idx_ff + 3'd1;
                  end
               end
               default: begin
                  step_in = '0;
               end
            endcase
         end

         S_OUT: begin
            // Wait until the output register is free, then present the result.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = own_pos_ff;
               rsp_dir_in   = own_dir_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         step_ff      <= '0;
         pass_ff      <= PASS_NEIGH;
         last_ff      <= 1'b0;
         sense_ff     <= 31'd65536;
         cw_ff        <= 32'sd65536;
         aw_ff        <= 32'sd65536;
         alw_ff       <= 32'sd65536;
         move_ff      <= 31'd3932;
         blend_ff     <= 17'd32768;
         for (int i = 0; i < 3; i++) begin
            own_pos_ff[i]  <= '0;
            own_dir_ff[i]  <= '0;
            coh_sum_ff[i]  <= '0;
            head_sum_ff[i] <= '0;
            rep_sum_ff[i]  <= '0;
         end
         near_cnt_ff  <= '0;
         drun_ff      <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         last_ff      <= last_in;
         sense_ff     <= sense_in;
         cw_ff        <= cw_in;
         aw_ff        <= aw_in;
         alw_ff       <= alw_in;
         move_ff      <= move_in;
         blend_ff     <= blend_in;
         own_pos_ff   <= own_pos_in;
         own_dir_ff   <= own_dir_in;
         coh_sum_ff   <= coh_sum_in;
         head_sum_ff  <= head_sum_in;
         rep_sum_ff   <= rep_sum_in;
         near_cnt_ff  <= near_cnt_in;
         drun_ff      <= drun_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nb_pos_ff  <= nb_pos_in;
      nb_dir_ff  <= nb_dir_in;
      vec_ff     <= vec_in;
      norm_ff    <= norm_in;
      coh_ff     <= coh_in;
      al_ff      <= al_in;
      len_ff     <= len_in;
      sq_sum_ff  <= sq_sum_in;
      sq_n_ff    <= sq_n_in;
      sq_r_ff    <= sq_r_in;
      sq_b_ff    <= sq_b_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      steer_ff   <= steer_in;
      nd_ff      <= nd_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      dneg_ff    <= dneg_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_dir_ff <= rsp_dir_in;
   end

endmodule

>>> hdl/boids_checker.sv
// ---------------------------------------------------------------------------
// Boids steering checker
// Port-level checks on request flow and result timing, bound to the block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module boids_checker
   import boids_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_type,
   input logic req_is_self,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A result that is not taken stays offered.
   `BOIDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

   // A real neighbor keeps the block busy after it is taken.
   `BOIDS_ASSERT_NEXT(a_busy_after_neighbor,
      req_valid && req_ready && req_type == REQ_NEIGHBOR && !req_is_self,
      !req_ready, "ready right after a neighbor request")

   // A load finishes in its own cycle.
   `BOIDS_ASSERT_NEXT(a_ready_after_load,
      req_valid && req_ready && req_type == REQ_LOAD,
      req_ready, "not ready after a load request")

   // Results only appear out of a busy period.
   `BOIDS_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready),
      "response raised while the block was idle")

endmodule

bind boids_agent_steering_update boids_checker u_boids_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_type    (req_chan.req_type),
   .req_is_self (req_chan.is_self),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready)
);
